// File: design/cht_pkg.sv
// ---------------------------------------------------------------------------
// cht_pkg
// shared widths, reset values, register indexes and outcome codes of the
// compact hash trie engine
// ---------------------------------------------------------------------------
`default_nettype none

package cht_pkg;

    // default geometry
    localparam int SLOT_COUNT_DEF = 65536;
    localparam int DSP_BITS_DEF   = 4;

    // field and register widths
    localparam int PRIME_W    = 25;
    localparam int MULT_W     = 63;
    localparam int ALPH_W     = 9;
    localparam int SYM_W      = 8;
    localparam int QUO_W      = 9;
    localparam int DVD_W      = 64;
    localparam int CHUNK_W    = 16;
    localparam int NUM_CHUNKS = DVD_W / CHUNK_W;
    localparam int PROD_W     = PRIME_W + CHUNK_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 63;
    localparam int OUTCOME_W  = 3;
    localparam int NODE_OUT_W = 16;
    localparam int STR_W      = 16;
    localparam int NCOUNT_W   = 17;

    // register reset values
    localparam logic [PRIME_W-1:0] PRIME_RST = 25'd16777259;
    localparam logic [MULT_W-1:0]  MULT_RST  = 63'd1099507040275;
    localparam logic [ALPH_W-1:0]  ALPH_RST  = 9'd256;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HASH_PRIME = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HASH_MULT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHABET   = 2'd2;

    // marks
    localparam logic [QUO_W-1:0] QUO_EMPTY    = '1;
    localparam logic [SYM_W-1:0] SYM_UNMAPPED = '1;
    localparam logic [ALPH_W-1:0] SYM_LIMIT   = 9'd255;
    localparam int ALPH_MARGIN = 2;
    localparam logic [PRIME_W-1:0] PRIME_MIN  = 25'd2;

    typedef enum logic [OUTCOME_W-1:0] {
        OC_FOUND     = 3'd0,
        OC_ABSENT    = 3'd1,
        OC_INSERTED  = 3'd2,
        OC_DUPLICATE = 3'd3,
        OC_ALPHABET  = 3'd4,
        OC_HASH      = 3'd5,
        OC_FULL      = 3'd6
    } outcome_t;

    // walk still alive shares the found code
    localparam outcome_t ST_ALIVE = OC_FOUND;

endpackage

`default_nettype wire

// File: design/compact_hash_trie_engine.sv
// ---------------------------------------------------------------------------
// compact_hash_trie_engine
// string store as a compact hash trie: linear-probed slot ram keyed by a
// scrambled hash of parent slot and symbol code, one byte per input word
// ---------------------------------------------------------------------------
//
//  channel   direction  handshake               payload
//  in        sink       in_valid / in_stall     mode, symbol_byte, first_symbol,
//                                               last_symbol, empty_string
//  out       source     out_valid / out_stall   outcome, final_node,
//                                               string_count, node_count
//  cfg       sink       cfg_valid / cfg_ready   cfg_index, cfg_data
//
//  one word at a time; the time a byte takes is set by the two passes of the
//  serial remainder unit and by the read-then-compare probe of each slot on
//  the slot ram; a word with no byte skips both
//  after reset a clearing pass over max(SLOT_COUNT, 256) addresses (65536 at the
//  defaults) empties the slot ram and the symbol map; in_stall is high then
//  a finished result sits in the output register, so new words are taken
//  while out_stall holds it; the engine waits only when a second result is due
//
`default_nettype none

module compact_hash_trie_engine import cht_pkg::*; #(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    parameter int DSP_BITS   = DSP_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // input words
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic                  mode,
    input  wire logic [SYM_W-1:0]      symbol_byte,
    input  wire logic                  first_symbol,
    input  wire logic                  last_symbol,
    input  wire logic                  empty_string,
    // result words
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic      [OUTCOME_W-1:0]  outcome,
    output logic      [NODE_OUT_W-1:0] final_node,
    output logic      [STR_W-1:0]      string_count,
    output logic      [NCOUNT_W-1:0]   node_count,
    // configuration writes
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int SLOT_W  = $clog2(SLOT_COUNT);
    localparam int SLOT_DW = QUO_W + DSP_BITS + 1;
    localparam int CLR_N   = (SLOT_COUNT > 256) ? SLOT_COUNT : 256;
    localparam int CLR_W   = $clog2(CLR_N);
    localparam int MCNT_W  = $clog2(NUM_CHUNKS + 1);
    localparam logic [SLOT_W-1:0]   ROOT_SLOT = SLOT_W'(SLOT_COUNT / 2);
    localparam logic [DSP_BITS-1:0] DSP_MAX   = '1;

    typedef enum logic [11:0] {
        S_CLEAR  = 12'b000000000001,
        S_IDLE   = 12'b000000000010,
        S_MAPEV  = 12'b000000000100,
        S_DIV1   = 12'b000000001000,
        S_MUL    = 12'b000000010000,
        S_LAUNCH = 12'b000000100000,
        S_DIV2   = 12'b000001000000,
        S_PROBE  = 12'b000010000000,
        S_PEV    = 12'b000100000000,
        S_FIN    = 12'b001000000000,
        S_TEV    = 12'b010000000000,
        S_EMIT   = 12'b100000000000
    } state_t;

    // control state
    state_t              state_reg,   state_next;
    logic [CLR_W-1:0]    clr_reg,     clr_next;
    logic [SLOT_W-1:0]   node_reg,    node_next;
    logic                tail_reg,    tail_next;
    outcome_t            status_reg,  status_next;
    logic [ALPH_W-1:0]   seen_reg,    seen_next;
    logic [SLOT_W:0]     nodes_reg,   nodes_next;
    logic [STR_W-1:0]    strings_reg, strings_next;
    logic                out_valid_reg, out_valid_next;
    logic [PRIME_W-1:0]  prime_reg;
    logic [MULT_W-1:0]   mult_reg;
    logic [ALPH_W-1:0]   alph_reg;

    // working payload
    logic                mode_reg,    mode_next;
    logic [SYM_W-1:0]    byte_reg,    byte_next;
    logic                last_reg,    last_next;
    logic [PRIME_W-1:0]  r1_reg,      r1_next;
    logic [DVD_W-1:0]    acc_reg,     acc_next;
    logic [PROD_W-1:0]   prod_reg,    prod_next;
    logic [1:0]          prod_sh_reg, prod_sh_next;
    logic [MCNT_W-1:0]   mcnt_reg,    mcnt_next;
    logic [QUO_W-1:0]    quo_reg,     quo_next;
    logic [SLOT_W-1:0]   pos_reg,     pos_next;
    logic [SLOT_W:0]     pcnt_reg,    pcnt_next;
    outcome_t            oc_reg,      oc_next;
    logic [OUTCOME_W-1:0]  outcome_reg;
    logic [NODE_OUT_W-1:0] final_node_reg;
    logic [STR_W-1:0]      string_count_reg;
    logic [NCOUNT_W-1:0]   node_count_reg;

    // memory ports
    logic                slot_we;
    logic [SLOT_W-1:0]   slot_waddr, slot_raddr;
    logic [SLOT_DW-1:0]  slot_wdata, slot_rdata;
    logic                long_we;
    logic [SLOT_W-1:0]   long_rdata;
    logic                map_we;
    logic [SYM_W-1:0]    map_waddr;
    logic [SYM_W-1:0]    map_wdata, map_rdata;

    // remainder unit
    logic                div_start;
    logic [DVD_W-1:0]    div_dividend;
    logic [PRIME_W-1:0]  div_divisor;
    logic                div_done;
    logic [PRIME_W-1:0]  div_rem;

    // helpers
    logic                ins;
    logic                accept;
    logic                emit_ok;
    logic [DVD_W-1:0]    mult_ext;
    logic [CHUNK_W-1:0]  chunk;
    logic [SYM_W-1:0]    sym_v;
    logic                unmapped;
    logic [PRIME_W-1:0]  quo_full;
    logic [QUO_W-1:0]    s_quo;
    logic [DSP_BITS-1:0] s_dsp;
    logic                s_term;
    logic                dsp_match;
    logic                cnt_small;

    assign ins       = mode_reg;
    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign emit_ok   = !out_valid_reg || !out_stall;

    assign div_divisor = (prime_reg < PRIME_MIN) ? PRIME_MIN : prime_reg;
    assign mult_ext    = {1'b0, mult_reg};
    assign chunk       = mult_ext[mcnt_reg[1:0]*CHUNK_W +: CHUNK_W];
    assign unmapped    = (map_rdata == SYM_UNMAPPED);
    assign sym_v       = unmapped ? seen_reg[SYM_W-1:0] : map_rdata;
    assign quo_full    = PRIME_W'(div_rem >> SLOT_W);

    // fields of the slot just read
    assign s_quo  = slot_rdata[SLOT_DW-1 -: QUO_W];
    assign s_dsp  = slot_rdata[DSP_BITS:1];
    assign s_term = slot_rdata[0];
    // short displacement field saturated means the side store holds it
    assign dsp_match = (s_dsp < DSP_MAX) ? (32'(s_dsp) == 32'(pcnt_reg))
                                         : ({1'b0, long_rdata} == pcnt_reg);
    assign cnt_small = 32'(pcnt_reg) < 32'(DSP_MAX);

    // next-state logic of the walk sequencer
    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        node_next      = node_reg;
        tail_next      = tail_reg;
        status_next    = status_reg;
        seen_next      = seen_reg;
        nodes_next     = nodes_reg;
        strings_next   = strings_reg;
        out_valid_next = out_valid_reg && out_stall;
        mode_next      = mode_reg;
        byte_next      = byte_reg;
        last_next      = last_reg;
        r1_next        = r1_reg;
        acc_next       = acc_reg;
        prod_next      = prod_reg;
        prod_sh_next   = prod_sh_reg;
        mcnt_next      = mcnt_reg;
        quo_next       = quo_reg;
        pos_next       = pos_reg;
        pcnt_next      = pcnt_reg;
        oc_next        = oc_reg;

        slot_we      = 1'b0;
        slot_waddr   = pos_reg;
        slot_wdata   = {QUO_EMPTY, {DSP_BITS{1'b0}}, 1'b0};
        slot_raddr   = pos_reg;
        long_we      = 1'b0;
        map_we       = 1'b0;
        map_waddr    = byte_reg;
        map_wdata    = seen_reg[SYM_W-1:0];
        div_start    = 1'b0;
        div_dividend = acc_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                // empty every slot and unmap every byte
                slot_we    = 1'b1;
                slot_waddr = clr_reg[SLOT_W-1:0];
                map_we     = 1'b1;
                map_waddr  = clr_reg[SYM_W-1:0];
                map_wdata  = SYM_UNMAPPED;
                clr_next   = clr_reg + 1'b1;
                if (clr_reg == CLR_W'(CLR_N - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    mode_next = mode;
                    byte_next = symbol_byte;
                    last_next = last_symbol;
                    if (first_symbol)
                    begin
                        node_next   = ROOT_SLOT;
                        tail_next   = 1'b0;
                        status_next = ST_ALIVE;
                    end
                    // map ram is read at symbol_byte on this edge
                    if (!empty_string && (first_symbol || status_reg == ST_ALIVE))
                    begin
                        state_next = S_MAPEV;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
            end
            S_MAPEV:
            begin
                priority if (unmapped && !ins)
                begin
                    status_next = OC_ABSENT;
                    state_next  = S_FIN;
                end
                else if (unmapped && (seen_reg >= SYM_LIMIT ||
                         ({1'b0, seen_reg} + 1'b1) >= {1'b0, alph_reg}))
                begin
                    status_next = OC_ALPHABET;
                    state_next  = S_FIN;
                end
                else if ({1'b0, sym_v} >= alph_reg)
                begin
                    // code granted earlier, alphabet lowered since
                    status_next = OC_ALPHABET;
                    state_next  = S_FIN;
                end
                else
                begin
                    if (unmapped)
                    begin
                        map_we    = 1'b1;
                        seen_next = seen_reg + 1'b1;
                    end
                    div_start    = 1'b1;
                    div_dividend = DVD_W'({sym_v, node_reg});
                    state_next   = S_DIV1;
                end
            end
            S_DIV1:
            begin
                if (div_done)
                begin
                    r1_next    = div_rem;
                    acc_next   = '0;
                    mcnt_next  = '0;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                // one partial product per cycle, summed in the next cycle
                if (mcnt_reg < MCNT_W'(NUM_CHUNKS))
                begin
                    prod_next    = {{CHUNK_W{1'b0}}, r1_reg} * {{PRIME_W{1'b0}}, chunk};
                    prod_sh_next = mcnt_reg[1:0];
                end
                if (mcnt_reg != '0)
                begin
                    acc_next = acc_reg + ({{(DVD_W - PROD_W){1'b0}}, prod_reg}
                                          << (int'(prod_sh_reg) * CHUNK_W));
                end
                mcnt_next = mcnt_reg + 1'b1;
                if (mcnt_reg == MCNT_W'(NUM_CHUNKS))
                begin
                    state_next = S_LAUNCH;
                end
            end
            S_LAUNCH:
            begin
                div_start  = 1'b1;
                state_next = S_DIV2;
            end
            S_DIV2:
            begin
                if (div_done)
                begin
                    if (quo_full >= (PRIME_W'(alph_reg) + PRIME_W'(ALPH_MARGIN)))
                    begin
                        status_next = OC_HASH;
                        state_next  = S_FIN;
                    end
                    else
                    begin
                        quo_next   = QUO_W'(quo_full);
                        pos_next   = div_rem[SLOT_W-1:0];
                        pcnt_next  = '0;
                        state_next = S_PROBE;
                    end
                end
            end
            S_PROBE:
            begin
                priority if (pcnt_reg == (SLOT_W + 1)'(SLOT_COUNT))
                begin
                    status_next = ins ? OC_FULL : OC_ABSENT;
                    state_next  = S_FIN;
                end
                else if (pos_reg == ROOT_SLOT)
                begin
                    // root holds no child but still counts
                    pos_next  = pos_reg + 1'b1;
                    pcnt_next = pcnt_reg + 1'b1;
                end
                else
                begin
                    state_next = S_PEV;
                end
            end
            S_PEV:
            begin
                priority if (s_quo == QUO_EMPTY)
                begin
                    if (!ins)
                    begin
                        status_next = OC_ABSENT;
                    end
                    else
                    begin
                        slot_we    = 1'b1;
                        slot_wdata = {quo_reg,
                                      cnt_small ? DSP_BITS'(pcnt_reg) : DSP_MAX, 1'b0};
                        long_we    = !cnt_small;
                        node_next  = pos_reg;
                        nodes_next = nodes_reg + 1'b1;
                        tail_next  = 1'b1;
                    end
                    state_next = S_FIN;
                end
                else if (!(ins && tail_reg) && s_quo == quo_reg && dsp_match)
                begin
                    node_next = pos_reg;
                    if (ins)
                    begin
                        tail_next = 1'b0;
                    end
                    state_next = S_FIN;
                end
                else
                begin
                    pos_next   = pos_reg + 1'b1;
                    pcnt_next  = pcnt_reg + 1'b1;
                    state_next = S_PROBE;
                end
            end
            S_FIN:
            begin
                slot_raddr = node_reg;
                priority if (!last_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (status_reg != ST_ALIVE)
                begin
                    oc_next    = status_reg;
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_TEV;
                end
            end
            S_TEV:
            begin
                priority if (!ins)
                begin
                    oc_next = s_term ? OC_FOUND : OC_ABSENT;
                end
                else if (s_term)
                begin
                    oc_next = OC_DUPLICATE;
                end
                else
                begin
                    slot_we    = 1'b1;
                    slot_waddr = node_reg;
                    slot_wdata = {slot_rdata[SLOT_DW-1:1], 1'b1};
                    if (strings_reg != '1)
                    begin
                        strings_next = strings_reg + 1'b1;
                    end
                    oc_next = OC_INSERTED;
                end
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (emit_ok)
                begin
                    out_valid_next = 1'b1;
                    node_next      = ROOT_SLOT;
                    tail_next      = 1'b0;
                    status_next    = ST_ALIVE;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            node_reg      <= ROOT_SLOT;
            tail_reg      <= 1'b0;
            status_reg    <= ST_ALIVE;
            seen_reg      <= '0;
            nodes_reg     <= (SLOT_W + 1)'(1);
            strings_reg   <= '0;
            out_valid_reg <= 1'b0;
            prime_reg     <= PRIME_RST;
            mult_reg      <= MULT_RST;
            alph_reg      <= ALPH_RST;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            node_reg      <= node_next;
            tail_reg      <= tail_next;
            status_reg    <= status_next;
            seen_reg      <= seen_next;
            nodes_reg     <= nodes_next;
            strings_reg   <= strings_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_HASH_PRIME: prime_reg <= cfg_data[PRIME_W-1:0];
                    CFG_HASH_MULT:  mult_reg  <= cfg_data[MULT_W-1:0];
                    CFG_ALPHABET:   alph_reg  <= cfg_data[ALPH_W-1:0];
                    default:        ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        mode_reg    <= mode_next;
        byte_reg    <= byte_next;
        last_reg    <= last_next;
        r1_reg      <= r1_next;
        acc_reg     <= acc_next;
        prod_reg    <= prod_next;
        prod_sh_reg <= prod_sh_next;
        mcnt_reg    <= mcnt_next;
        quo_reg     <= quo_next;
        pos_reg     <= pos_next;
        pcnt_reg    <= pcnt_next;
        oc_reg      <= oc_next;
        if (state_reg == S_EMIT && emit_ok)
        begin
            outcome_reg      <= oc_reg;
            final_node_reg   <= NODE_OUT_W'(node_reg);
            string_count_reg <= strings_reg;
            node_count_reg   <= NCOUNT_W'(nodes_reg);
        end
    end

    assign out_valid    = out_valid_reg;
    assign outcome      = outcome_reg;
    assign final_node   = final_node_reg;
    assign string_count = string_count_reg;
    assign node_count   = node_count_reg;

    // slot ram: quotient, short displacement, terminal flag
    cht_ram #(
        .WIDTH (SLOT_DW),
        .DEPTH (SLOT_COUNT)
    ) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    // side store for displacements that overflow the short field
    cht_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (SLOT_COUNT)
    ) u_long_ram (
        .clk   (clk),
        .we    (long_we),
        .waddr (pos_reg),
        .wdata (pcnt_reg[SLOT_W-1:0]),
        .raddr (slot_raddr),
        .rdata (long_rdata)
    );

    // byte to dense code map
    cht_ram #(
        .WIDTH (SYM_W),
        .DEPTH (256)
    ) u_map_ram (
        .clk   (clk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .raddr (symbol_byte),
        .rdata (map_rdata)
    );

    // shared remainder unit for both hash reductions
    cht_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .remainder (div_rem)
    );

endmodule

`default_nettype wire

// File: design/cht_ram.sv
// ---------------------------------------------------------------------------
// cht_ram
// generic single write port ram with one registered read port
// ---------------------------------------------------------------------------
`default_nettype none

module cht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: design/cht_div.sv
// ---------------------------------------------------------------------------
// cht_div
// bit-serial restoring remainder unit, one dividend bit per cycle
// ---------------------------------------------------------------------------
`default_nettype none

module cht_div import cht_pkg::*; (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [DVD_W-1:0]   dividend,
    input  wire logic [PRIME_W-1:0] divisor,
    output logic                    done,
    output logic      [PRIME_W-1:0] remainder
);

    localparam int CNT_W = $clog2(DVD_W);

    logic [DVD_W-1:0]   dvd_reg;
    logic [PRIME_W-1:0] dsr_reg;
    logic [PRIME_W-1:0] rem_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;

    logic [PRIME_W:0]   shifted;
    logic [PRIME_W:0]   diff;
    logic [PRIME_W-1:0] rem_next;

    always_comb
    begin
        shifted  = {rem_reg, dvd_reg[DVD_W-1]};
        diff     = shifted - {1'b0, dsr_reg};
        rem_next = (shifted >= {1'b0, dsr_reg}) ? diff[PRIME_W-1:0] : shifted[PRIME_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DVD_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[DVD_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire
